[hw/rtl/kdv_pkg.sv]
// Package for the k-mer delta varint encoder: state, command and status types,
// group-size constants and the group select function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kdv_pkg;

  localparam int unsigned CodeBits  = 64;
  localparam int unsigned GroupBits = 15;
  localparam int unsigned NumGroups = 5;
  localparam int unsigned IdxBits   = 3;
  localparam int unsigned FragBits  = 16;

  typedef logic [IdxBits-1:0]   grp_idx_t;
  typedef logic [GroupBits-1:0] group_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEND
  } kdv_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the new code and form the delta
    logic start;  // pick the highest group and present it
    logic next;   // step down to the next lower group
  } kdv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_frag;  // the presented fragment holds the low group
  } kdv_status_t;

  // Selects one 15-bit group of the delta; the top group holds four bits.
  function automatic group_t kdv_group(input logic [CodeBits-1:0] delta,
                                       input grp_idx_t idx);
    group_t g;
    g = '0;
    case (idx)
      3'd0:    g = delta[14:0];
      3'd1:    g = delta[29:15];
      3'd2:    g = delta[44:30];
      3'd3:    g = delta[59:45];
      3'd4:    g = {11'd0, delta[63:60]};
      default: g = '0;
    endcase
    return g;
  endfunction

  // Index of the highest nonzero group, zero when only the low group is needed.
  function automatic grp_idx_t kdv_top_group(input logic [CodeBits-1:0] delta);
    grp_idx_t idx;
    if (delta[63:60] != '0) begin
      idx = 3'd4;
    end else if (delta[59:45] != '0) begin
      idx = 3'd3;
    end else if (delta[44:30] != '0) begin
      idx = 3'd2;
    end else if (delta[29:15] != '0) begin
      idx = 3'd1;
    end else begin
      idx = 3'd0;
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/kdv_ctrl.sv]
// Controller state machine of the k-mer delta varint encoder.
// Depends on kdv_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module kdv_ctrl
  import kdv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  kdv_status_t      status_i,
  output kdv_cmd_t         cmd_o
);

  kdv_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready_i && status_i.last_frag) begin
          state_d = in_valid_i ? ST_LOAD : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs. A new request is taken while the final fragment leaves.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_LOAD: begin
        cmd_o.start = 1'b1;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i && status_i.last_frag;
        cmd_o.next  = out_ready_i && !status_i.last_frag;
      end
      default: ;
    endcase
    cmd_o.load = in_ready_o && in_valid_i;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/kdv_datapath.sv]
// Datapath of the k-mer delta varint encoder: previous code, delta register,
// group index counter and the fragment output register. Depends on kdv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kdv_datapath
  import kdv_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  kdv_cmd_t                  cmd_i,
  input  wire logic [CodeBits-1:0]  code_i,
  output kdv_status_t               status_o,
  output logic [FragBits-1:0]       frag_o,
  output logic                      last_o
);

  logic [CodeBits-1:0] prev_q;
  logic [CodeBits-1:0] delta_q;
  grp_idx_t            idx_q, idx_d;
  logic [FragBits-1:0] frag_q, frag_d;

  // Previous code resets to zero; the delta wraps modulo 2^64.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (cmd_i.load) begin
      prev_q <= code_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      delta_q <= code_i - prev_q;
    end
  end

  // Group index and the fragment presented for it; the end flag marks group zero.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = kdv_top_group(delta_q);
    end else if (cmd_i.next) begin
      idx_d = idx_q - 3'd1;
    end
    frag_d = {(idx_d == 3'd0), kdv_group(delta_q, idx_d)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start || cmd_i.next) begin
      frag_q <= frag_d;
    end
  end

  assign status_o.last_frag = (idx_q == 3'd0);
  assign frag_o             = frag_q;
  assign last_o             = (idx_q == 3'd0);

endmodule

`default_nettype wire

[hw/rtl/kmer_delta_varint_encoder.sv]
// Encodes an ascending stream of 64-bit k-mer codes as delta varints: each
// code minus the previous one (modulo 2^64, starting from zero) leaves as one
// to five 16-bit fragments, highest 15-bit group first, and only the final
// fragment carries bit 15 and tlast. The delta is registered as the code is
// accepted, the load state then puts the highest nonzero group into the
// output register, and one fragment leaves per cycle while tready is high. The
// next code is accepted in the same cycle that the final fragment is taken.
// Depends on kdv_pkg, kdv_ctrl and kdv_datapath.
`timescale 1ns / 1ps
`default_nettype none

module kmer_delta_varint_encoder
  import kdv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [63:0] kmer_code
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [15:0] fragment
  output logic             m_axis_tlast_o    // last
);

  kdv_cmd_t    cmd;
  kdv_status_t status;

  // Sequencing of load, group selection and fragment output.
  kdv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Delta formation and fragment generation.
  kdv_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .code_i   (s_axis_tdata_i),
    .status_o (status),
    .frag_o   (m_axis_tdata_o),
    .last_o   (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

[sim/kmer_delta_varint_encoder_tb.sv]
// Self-checking testbench for kmer_delta_varint_encoder: drives k-mer codes, predicts
// the delta varint fragments of each accepted code and checks every fragment in order.
// Depends on kdv_pkg and the encoder RTL.
`timescale 1ns / 1ps

module kmer_delta_varint_encoder_tb
  import kdv_pkg::*;
();

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DrainCycles = 12;

  // One expected fragment on the output stream.
  typedef struct packed {
    logic [FragBits-1:0] frag;
    logic                last;
  } fragment_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;   // [63:0] kmer_code
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // [15:0] fragment
  logic        m_axis_tlast_o;        // last

  // Encoder state copy and the fragments still owed by the block.
  logic [CodeBits-1:0] last_written_code = '0;
  fragment_t           pending_frags[$];

  // Idling controls shared by the sender task and the receiver process.
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        recv_hold = 1'b0;

  int unsigned codes_sent = 0;
  int unsigned frags_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  kmer_delta_varint_encoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  // Splits the delta to the last written code into 15-bit groups and queues them
  // highest group first; only the low group carries the end flag.
  task automatic predict_fragments(input logic [CodeBits-1:0] code);
    logic [CodeBits-1:0]  remain;
    logic [GroupBits-1:0] groups[0:NumGroups-1];
    fragment_t            item;
    int                   count;
    remain = code - last_written_code;
    count = 0;
    do begin
      groups[count] = remain[GroupBits-1:0];
      remain = remain >> GroupBits;
      count++;
    end while (remain != '0 && count < NumGroups);
    for (int k = count - 1; k >= 0; k--) begin
      item.frag = {(k == 0), groups[k]};
      item.last = (k == 0);
      pending_frags.insert(pending_frags.size(), item);
    end
    last_written_code = code;
  endtask

  // Offers one code, with random idle cycles first, and waits for the request to be taken.
  task automatic send_code(input logic [CodeBits-1:0] code);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= code;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_fragments(code);
    codes_sent++;
  endtask

  // Stops offering requests, waits until every predicted fragment has come out,
  // then lets the pipeline settle.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_frags.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Group boundaries, equal codes, wrapping deltas and the extremes of the code.
  task automatic test_directed_edges();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_code(64'd5);                       // first code is taken against zero
    send_code(64'd5);                       // equal codes give a zero delta
    send_code(64'd5 + 64'h7FFF);            // largest one-fragment delta
    send_code(64'd5 + 64'h7FFF + 64'h8000); // smallest two-fragment delta
    send_code(64'h0000_0000_4000_0000);
    send_code(64'h0000_0000_7FFF_FFFF);
    send_code(64'h0000_2000_0000_0000);
    send_code(64'h0000_3FFF_FFFF_FFFF);
    send_code(64'h1000_0000_0000_0000);     // delta reaching group three, bits 59:45
    send_code(64'hFFFF_FFFF_FFFF_FFFF);     // highest code
    send_code(64'h0000_0000_0000_0000);     // wraps to a delta of one
    send_code(64'hFFFF_FFFF_FFFF_FFFF);     // all-ones delta, five fragments
    send_code(64'hFFFF_FFFF_FFFF_FFFE);     // descending by one wraps to all ones
    send_code(64'hAAAA_AAAA_AAAA_AAAA);
    send_code(64'h5555_5555_5555_5555);
    send_code(64'h5555_5555_5555_5555);
    wait_drained();
  endtask

  // Mostly ascending runs with deltas of every bit length, plus some arbitrary codes.
  task automatic test_random_phase(input int unsigned count, input int unsigned gap_pct,
                                   input int unsigned stall_pct);
    logic [CodeBits-1:0] delta;
    logic [CodeBits-1:0] code;
    int unsigned         nbits;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        code = {$urandom, $urandom};
      end else begin
        nbits = $urandom_range(0, CodeBits);
        delta = {$urandom, $urandom};
        if (nbits < CodeBits) begin
          delta = delta & ((64'd1 << nbits) - 64'd1);
        end
        code = last_written_code + delta;
      end
      send_code(code);
    end
    wait_drained();
  endtask

  // Holds the output off for a long stretch while codes keep coming, so the input stalls.
  task automatic test_output_backpressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    fork
      begin
        recv_hold <= 1'b1;
        repeat (200) @(posedge clk_i);
        recv_hold <= 1'b0;
      end
      begin
        repeat (6) send_code(last_written_code + {$urandom, $urandom});
      end
    join
    wait_drained();
  endtask

  // Receiver: random stalls, or a forced hold-off while one is requested.
  always @(posedge clk_i) begin
    if (recv_hold) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compares each fragment taken from the block with the oldest prediction.
  always @(posedge clk_i) begin
    fragment_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      frags_seen++;
      if (pending_frags.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("[%0t] unexpected fragment %h last %b", $realtime, m_axis_tdata_o,
                   m_axis_tlast_o);
        end
      end else begin
        want = pending_frags.pop_front();
        if (m_axis_tdata_o !== want.frag || m_axis_tlast_o !== want.last) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("[%0t] fragment %0d: expected %h last %b, got %h last %b", $realtime,
                     frags_seen, want.frag, want.last, m_axis_tdata_o, m_axis_tlast_o);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d fragments pending", cycle_count,
               pending_frags.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_random_phase(50, 0, 0);
    test_random_phase(50, 51, 0);
    test_output_backpressure();
    test_random_phase(50, 0, 51);
    test_random_phase(50, 38, 38);
    wait_drained();
    $display("Encoded %0d k-mer codes into %0d fragments under free flow, input gaps,",
             codes_sent, frags_seen);
    $display("output stalls, both at once and a long output hold-off; %0d errors.",
             error_count);
    if (error_count == 0 && pending_frags.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
